### src/nls_pkg.sv
`default_nettype none

package nls_pkg;

  // Default bound on the token length, in characters.
  localparam int MAX_TOKEN_LEN_DEFAULT = 32;

  localparam logic [5:0] DEFAULT_BASE_RESET = 6'd10;
  localparam logic [5:0] BASE_HEX        = 6'd16;
  localparam logic [5:0] BASE_DEC        = 6'd10;
  localparam logic [5:0] BASE_BIN        = 6'd2;
  localparam logic [5:0] LONG_BASE_LIMIT = 6'd20;
  localparam logic [5:0] POS_SATURATE    = 6'd63;
  localparam logic [6:0] POS_NONE        = 7'h7F;

  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PERIOD  = 8'h2E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_UPPER_E = 8'h45;
  localparam logic [7:0] CH_LOWER_E = 8'h65;
  localparam logic [7:0] CH_UPPER_L = 8'h4C;
  localparam logic [7:0] CH_LOWER_L = 8'h6C;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_F = 8'h66;

  typedef enum logic [2:0] {
    NT_INVALID = 3'd0,
    NT_INT     = 3'd1,
    NT_LONG    = 3'd2,
    NT_DOUBLE  = 3'd3,
    NT_SINGLE_FLOAT = 3'd4,
    NT_DOUBLE_FLOAT = 3'd5
  } num_type_t;

  typedef struct packed {
    logic [63:0]       acc;
    logic [5:0]        pos;
    logic [5:0]        base;
    logic              prefix_seen;
    logic              neg;
    logic signed [6:0] exp_pos;
    logic signed [6:0] per_pos;
    logic              err;
    logic [1:0]        lead_signs;
    logic              sig_seen;
  } scan_state_t;

  typedef struct packed {
    num_type_t         num_type;
    logic [63:0]       value;
    logic              offset;
    logic [5:0]        base;
    logic signed [6:0] per_pos;
    logic signed [6:0] exp_pos;
  } scan_result_t;

endpackage

`default_nettype wire

### src/nls_step.sv
`default_nettype none

module nls_step import nls_pkg::*; #(
  parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEFAULT
) (
  input  scan_state_t  st,
  input  logic [7:0]   ch,
  input  logic         is_last,
  input  logic [5:0]   default_base,
  output scan_state_t  st_next,
  output scan_result_t res
);

  localparam logic [6:0] MaxLen = 7'(MAX_TOKEN_LEN);

  always_comb begin
    scan_state_t n;
    logic        err;
    logic [5:0]  d;
    logic        d_ok;
    logic        offset;
    logic        forced_long;
    logic        forced_single;
    logic        is_exp_char;
    logic        is_long_char;
    logic        is_single_char;

    n = st;
    offset = 1'b0;
    forced_long = 1'b0;
    forced_single = 1'b0;
    err = st.err | ({1'b0, st.pos} >= MaxLen);

    d = 6'd0;
    d_ok = 1'b0;
    if (ch inside {[CH_ZERO:CH_NINE]}) begin
      d = 6'(ch - CH_ZERO);
      d_ok = 1'b1;
    end else if (ch inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
      d = 6'(ch - CH_UPPER_A) + 6'd10;
      d_ok = 1'b1;
    end else if (ch inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
      d = 6'(ch - CH_LOWER_A) + 6'd10;
      d_ok = 1'b1;
    end

    is_exp_char = (st.base == BASE_DEC) && (ch == CH_UPPER_E || ch == CH_LOWER_E);
    is_long_char = is_last && (st.base < LONG_BASE_LIMIT) &&
                   (ch == CH_UPPER_L || ch == CH_LOWER_L);
    is_single_char = is_last && !st.exp_pos[6] && (ch == CH_UPPER_F || ch == CH_LOWER_F);

    if (!err) begin
      if (ch == CH_DOLLAR || ch == CH_HASH || ch == CH_PERCENT) begin
        if (st.pos < 6'd2 && !st.prefix_seen) begin
          n.prefix_seen = 1'b1;
          n.base = (ch == CH_DOLLAR) ? BASE_HEX : ((ch == CH_HASH) ? BASE_DEC : BASE_BIN);
        end else begin
          err = 1'b1;
        end
      end else if (ch == CH_PLUS || ch == CH_MINUS) begin
        if (is_last) begin
          offset = 1'b1;
          if (ch == CH_MINUS) n.neg = !st.neg;
        end else if (st.pos > 6'd1 && {1'b0, st.pos} != 7'(st.exp_pos + 7'sd1)) begin
          err = 1'b1;
        end else begin
          if (ch == CH_MINUS && st.pos < 6'd2) n.neg = 1'b1;
          if (!st.sig_seen) begin
            // A second sign, or one after a period or marker, spoils a float.
            if (st.lead_signs != 2'd0 || !st.per_pos[6] || !st.exp_pos[6]) begin
              n.lead_signs = 2'd2;
            end else begin
              n.lead_signs = 2'd1;
            end
          end
        end
      end else if (is_exp_char) begin
        if (!st.exp_pos[6] || st.pos == 6'd0) begin
          err = 1'b1;
        end else begin
          n.exp_pos = {1'b0, st.pos};
        end
      end else if (is_long_char) begin
        forced_long = 1'b1;
      end else if (is_single_char) begin
        forced_single = 1'b1;
      end else if (ch == CH_PERIOD) begin
        if (!st.per_pos[6]) begin
          err = 1'b1;
        end else begin
          n.per_pos = {1'b0, st.pos};
        end
      end else if (d_ok && d < st.base) begin
        if (st.exp_pos[6]) begin
          n.acc = st.acc * {58'd0, st.base} + {58'd0, d};
          if (!st.sig_seen && st.lead_signs <= 2'd1) n.sig_seen = 1'b1;
        end
      end else begin
        err = 1'b1;
      end
    end

    n.err = err;
    if (st.pos < POS_SATURATE) n.pos = st.pos + 6'd1;

    res.base = n.base;
    res.per_pos = n.per_pos;
    res.exp_pos = n.exp_pos;
    if (n.err) begin
      res.num_type = NT_INVALID;
    end else if (!n.exp_pos[6]) begin
      if (!n.sig_seen) begin
        res.num_type = NT_INVALID;
      end else begin
        res.num_type = forced_single ? NT_SINGLE_FLOAT : NT_DOUBLE_FLOAT;
      end
    end else if (!n.per_pos[6]) begin
      res.num_type = NT_DOUBLE;
    end else begin
      res.num_type = forced_long ? NT_LONG : NT_INT;
    end
    if (res.num_type == NT_INVALID) begin
      res.value = 64'd0;
      res.offset = 1'b0;
    end else begin
      res.value = n.neg ? (64'd0 - n.acc) : n.acc;
      res.offset = offset;
    end

    if (is_last) begin
      n = '0;
      n.base = default_base;
      n.exp_pos = POS_NONE;
      n.per_pos = POS_NONE;
    end
    st_next = n;
  end

endmodule

`default_nettype wire

### src/numeric_literal_scanner_top.sv
// Each character waits in the input register until it is scanned, which updates the
// scan state; scanning a last character loads its result into the result register.
// Throughput: one character per cycle while no result is held downstream.
// A stalled result holds the last character in the input register until it is taken.
// Reset (rst, synchronous, active high) sets the default base to 10, clears the token
// state and empties both the input register and the result register.
`default_nettype none

module numeric_literal_scanner_top import nls_pkg::*; #(
  parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wen,
  input  wire logic [5:0]        cfg_wdata,
  input  wire logic              char_valid,
  output logic                   char_stall,
  input  wire logic [7:0]        ch,
  input  wire logic              is_last,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output logic [2:0]             number_type,
  output logic signed [63:0]     number_value,
  output logic                   is_offset,
  output logic [5:0]             base_used,
  output logic signed [6:0]      period_at,
  output logic signed [6:0]      exponent_at
);

  // The default base only reaches the scan state when a token ends, so a
  // new default takes effect from the token after the next one completes.
  logic [5:0] default_base;

  // Input register: one character transaction waiting to be scanned.
  logic       in_full;
  logic [7:0] in_ch;
  logic       in_last;

  scan_state_t  st;
  scan_state_t  st_next;
  scan_result_t res;

  logic out_free;
  logic advance;
  logic accept;

  // A character that produces no result never waits; a last character waits
  // only while an earlier result is still held by the downstream side.
  assign out_free   = !result_valid || !result_stall;
  assign advance    = in_full && (!in_last || out_free);
  assign char_stall = in_full && !advance;
  assign accept     = char_valid && !char_stall;

  nls_step #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_step (
    .st          (st),
    .ch          (in_ch),
    .is_last     (in_last),
    .default_base(default_base),
    .st_next     (st_next),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      default_base <= DEFAULT_BASE_RESET;
    end else if (cfg_wen) begin
      default_base <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= accept || (in_full && !advance);
    end
    if (accept) begin
      in_ch <= ch;
      in_last <= is_last;
    end
  end

  // Reset state: empty accumulator, position zero, reset base, no period or marker.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= {64'd0, 6'd0, DEFAULT_BASE_RESET, 1'b0, 1'b0, POS_NONE, POS_NONE,
             1'b0, 2'd0, 1'b0};
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register: loaded when a last character is scanned.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && in_last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (advance && in_last) begin
      number_type  <= res.num_type;
      number_value <= res.value;
      is_offset    <= res.offset;
      base_used    <= res.base;
      period_at    <= res.per_pos;
      exponent_at  <= res.exp_pos;
    end
  end

`ifndef ASSERT_OFF
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    char_stall |-> (in_full && in_last && result_valid && result_stall))
    else $error("character stalled without a held result");

  a_token_restart: assert property (@(posedge clk) disable iff (rst)
    (advance && in_last) |=> (st.pos == 6'd0 && !st.err && st.acc == 64'd0))
    else $error("scan state not restarted after a token");

  a_invalid_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && number_type == NT_INVALID) |-> (number_value == 64'd0 && !is_offset))
    else $error("invalid result carries a value or offset");

  a_float_marker: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (number_type == NT_SINGLE_FLOAT || number_type == NT_DOUBLE_FLOAT))
      |-> !exponent_at[6])
    else $error("float result without an exponent marker");
`endif

endmodule

`default_nettype wire
